### rtl/led_chain_frame_serializer_unit_defines.svh
// Assertion macros for the checker file of the LED chain serializer.
`ifndef LED_CHAIN_FRAME_SERIALIZER_UNIT_DEFINES_SVH
`define LED_CHAIN_FRAME_SERIALIZER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LCFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcfs assertion failed");

// Next-cycle implication, checked during reset as well.
`define LCFS_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lcfs assertion failed");

`endif

### rtl/lcfs_pkg.sv
// Shared types and constants of the LED chain frame serializer.
package lcfs_pkg;

   // Command codes carried in the input selector.
   localparam logic [2:0] MODE_RESET = 3'd0;
   localparam logic [2:0] MODE_SYNC  = 3'd1;
   localparam logic [2:0] MODE_START = 3'd2;
   localparam logic [2:0] MODE_PIXEL = 3'd3;
   localparam logic [2:0] MODE_FINAL = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_LED_COUNT       = 2'd0;
   localparam logic [1:0] REG_BLANK_PER_LED   = 2'd1;
   localparam logic [1:0] REG_HALF_BIT_TICKS  = 2'd2;
   localparam logic [1:0] REG_LONG_BLANK_HALF = 2'd3;

   // Register reset values.
   localparam logic [10:0] LED_COUNT_RESET       = 11'd10;
   localparam logic [9:0]  BLANK_PER_LED_RESET   = 10'd180;
   localparam logic [7:0]  HALF_BIT_TICKS_RESET  = 8'd3;
   localparam logic [15:0] LONG_BLANK_HALF_RESET = 16'd500;

   // Bit patterns, sent MSB first.
   localparam int HEADER_BITS = 19;
   localparam int SYNC_BITS   = 30;
   localparam logic [HEADER_BITS-1:0] RESET_PATTERN = 19'h7FFF4;
   localparam logic [HEADER_BITS-1:0] START_PATTERN = 19'h7FFF2;
   localparam logic [SYNC_BITS-1:0]   SYNC_PATTERN  = 30'h3FFF8800;

   // Pixel layout: three channels, each a zero bit and a 12-bit field.
   localparam int CHANNEL_FIELD_BITS = 12;
   localparam int PIXEL_BITS = 3 * (1 + CHANNEL_FIELD_BITS);

   // Widest pattern held by the symbol sequencer and its bit counter.
   localparam int SYM_BITS   = PIXEL_BITS;
   localparam int COUNT_BITS = $clog2(SYM_BITS + 1);

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Sync blank limits and the cap of the pixel slot counter.
   localparam int PROD_BITS = 21;
   localparam logic [17:0] FIRST_MAX = 18'h3FFFF;
   localparam logic [10:0] SLOT_MAX  = 11'h7FF;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_LONG,
      TAIL_SYNC
   } tail_type;

   typedef struct packed {
      logic [10:0] led_count;
      logic [9:0]  blank_per_led;
      logic [7:0]  half_bit_ticks;
      logic [15:0] long_blank_half;
   } cfg_type;

   // One classified command waiting for the back end.
   typedef struct packed {
      logic [SYM_BITS-1:0]   pattern;
      logic [COUNT_BITS-1:0] nbits;
      tail_type              tail;
      logic                  err;
   } desc_type;

endpackage

### rtl/lcfs_front.sv
// Front end: accepts commands, checks pixel order and builds descriptors.
module lcfs_front import lcfs_pkg::*; #(
   parameter int MAX_LEDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        q_full,
   output logic        q_push,
   output desc_type    q_data
);

   localparam int LIMIT_BITS = $clog2(MAX_LEDS + 1);
   localparam int CMP_BITS   = (LIMIT_BITS > 11) ? LIMIT_BITS : 11;

   logic [10:0]         next_slot_ff;
   logic [10:0]         next_slot_in;
   logic [7:0]          red;
   logic [7:0]          green;
   logic [7:0]          blue;
   logic [2:0]          brightness;
   logic [9:0]          pixel_slot;
   logic [CMP_BITS-1:0] lc_ext;
   logic [CMP_BITS-1:0] max_ext;
   logic [CMP_BITS-1:0] limit;
   logic                slot_err;
   logic                accept;

   // Shift a color into its channel field, dropping bits above the field.
   function automatic logic [CHANNEL_FIELD_BITS-1:0] chan_field(input logic [7:0] color,
                                                               input logic [2:0] shift);
      logic [14:0] wide;
      wide = 15'(color) << shift;
      return wide[CHANNEL_FIELD_BITS-1:0];
   endfunction

   assign red        = req_tdata[7:0];
   assign green      = req_tdata[15:8];
   assign blue       = req_tdata[23:16];
   assign brightness = req_tdata[26:24];
   assign pixel_slot = req_tdata[36:27];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Slot check against the expected slot and the usable chain length.
   assign lc_ext   = CMP_BITS'(cfg.led_count);
   assign max_ext  = CMP_BITS'(MAX_LEDS);
   assign limit    = (lc_ext < max_ext) ? lc_ext : max_ext;
   assign slot_err = ({1'b0, pixel_slot} != next_slot_ff) ||
                     (CMP_BITS'(pixel_slot) >= limit);

   // Classify the command into a pattern, a bit count and a closing blank.
   always_comb begin
      q_push         = accept;
      q_data.pattern = '0;
      q_data.nbits   = '0;
      q_data.tail    = TAIL_NONE;
      q_data.err     = 1'b0;
      next_slot_in   = next_slot_ff;
      unique case (req_tuser)
         MODE_RESET: begin
            q_data.pattern = {RESET_PATTERN, (SYM_BITS - HEADER_BITS)'(0)};
            q_data.nbits   = COUNT_BITS'(HEADER_BITS);
            q_data.tail    = TAIL_LONG;
         end
         MODE_SYNC: begin
            q_data.pattern = {SYNC_PATTERN, (SYM_BITS - SYNC_BITS)'(0)};
            q_data.nbits   = COUNT_BITS'(SYNC_BITS);
            q_data.tail    = TAIL_SYNC;
         end
         MODE_START: begin
            q_data.pattern = {START_PATTERN, (SYM_BITS - HEADER_BITS)'(0)};
            q_data.nbits   = COUNT_BITS'(HEADER_BITS);
            if (accept) begin
               next_slot_in = '0;
            end
         end
         MODE_PIXEL: begin
            q_data.pattern = {1'b0, chan_field(red, brightness),
                              1'b0, chan_field(green, brightness),
                              1'b0, chan_field(blue, brightness)};
            q_data.nbits   = COUNT_BITS'(PIXEL_BITS);
            q_data.err     = slot_err;
            if (accept && (next_slot_ff != SLOT_MAX)) begin
               next_slot_in = next_slot_ff + 11'd1;
            end
         end
         MODE_FINAL: begin
            q_data.pattern = {START_PATTERN, (SYM_BITS - HEADER_BITS)'(0)};
            q_data.nbits   = COUNT_BITS'(HEADER_BITS);
            q_data.tail    = TAIL_LONG;
         end
         default: begin
            // Unused codes are taken and dropped.
            q_push = 1'b0;
         end
      endcase
   end

   // Expected pixel slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
      end else begin
         next_slot_ff <= next_slot_in;
      end
   end

endmodule

### rtl/lcfs_queue.sv
// Short command queue between the front end and the symbol sequencer.
module lcfs_queue import lcfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head,
   output logic     full,
   output logic     empty
);

   desc_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Wrap a pointer at the queue depth.
   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] ptr);
      return (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/lcfs_back.sv
// Back end: walks each command, emitting one line symbol a cycle unless stalled.
module lcfs_back import lcfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  desc_type    head,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   desc_type             cur_ff;
   desc_type             cur_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic [PROD_BITS-1:0] prod_ff;
   logic [17:0]          sync_first;
   desc_type             src;
   logic                 have;
   logic                 adv;
   logic                 fire;

   logic                 rsp_valid_ff;
   logic                 fl_ff, fl_in;
   logic [17:0]          ft_ff, ft_in;
   logic                 sl_ff, sl_in;
   logic [15:0]          st_ff, st_in;
   logic                 err_ff, err_in;
   logic                 last_ff, last_in;

   // Sync blank length, registered straight from the configuration.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(cfg.led_count) * PROD_BITS'(cfg.blank_per_led);
   end

   always_comb begin
      if (prod_ff == '0) begin
         sync_first = '0;
      end else if ((prod_ff - 1'b1) > PROD_BITS'(FIRST_MAX)) begin
         sync_first = FIRST_MAX;
      end else begin
         sync_first = 18'(prod_ff - 1'b1);
      end
   end

   // With a command at hand, a new symbol is built when the output register is free or drains.
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign src   = busy_ff ? cur_ff : head;
   assign have  = busy_ff || !q_empty;
   assign fire  = adv && have;
   assign q_pop = fire && !busy_ff;

   // Symbol for the current position of the command.
   always_comb begin
      cur_in  = src;
      err_in  = src.err;
      fl_in   = 1'b0;
      ft_in   = 18'(cfg.half_bit_ticks);
      sl_in   = 1'b0;
      st_in   = 16'(cfg.half_bit_ticks);
      last_in = 1'b1;
      if (src.nbits != '0) begin
         fl_in          = src.pattern[SYM_BITS-1];
         sl_in          = !src.pattern[SYM_BITS-1];
         last_in        = (src.nbits == COUNT_BITS'(1)) && (src.tail == TAIL_NONE);
         cur_in.pattern = src.pattern << 1;
         cur_in.nbits   = src.nbits - 1'b1;
      end else begin
         case (src.tail)
            TAIL_SYNC: begin
               ft_in = sync_first;
               st_in = 16'd1;
            end
            default: begin
               ft_in = 18'(cfg.long_blank_half);
               st_in = cfg.long_blank_half;
            end
         endcase
      end
      busy_in = busy_ff;
      if (fire) begin
         busy_in = !last_in;
      end
   end

   // Sequencer state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (adv) begin
            rsp_valid_ff <= have;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_ff  <= cur_in;
         fl_ff   <= fl_in;
         ft_ff   <= ft_in;
         sl_ff   <= sl_in;
         st_ff   <= st_in;
         err_ff  <= err_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, st_ff, sl_ff, ft_ff, fl_ff};
   assign rsp_tlast  = last_ff;

endmodule

### rtl/led_chain_frame_serializer_unit.sv
// Top level of the LED chain frame serializer with its register port.
// With the sequencer idle, an accepted command is written into the queue, and the sequencer
// then loads its first symbol into the output register, from which it is offered for transfer.
// Output runs at one symbol per clock while the receiver does not stall it,
// and a two-entry queue lets input run ahead.
// Reset is synchronous and active high: registers return to their defaults,
// the pixel counter, the queue and the output register are cleared.
module led_chain_frame_serializer_unit import lcfs_pkg::*; #(
   parameter int MAX_LEDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: red[7:0], green[15:8], blue[23:16], brightness[26:24], pixel_slot[36:27]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // req_tuser: mode[2:0]
   input  logic [2:0]  req_tuser,
   // rsp_tdata: first_level[0], first_ticks[18:1], second_level[19],
   // second_ticks[35:20], sequence_error[36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff;
   logic       csr_write;
   logic [1:0] csr_index;
   logic       q_push;
   desc_type   q_data;
   logic       q_pop;
   desc_type   q_head;
   logic       q_full;
   logic       q_empty;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count       <= LED_COUNT_RESET;
         cfg_ff.blank_per_led   <= BLANK_PER_LED_RESET;
         cfg_ff.half_bit_ticks  <= HALF_BIT_TICKS_RESET;
         cfg_ff.long_blank_half <= LONG_BLANK_HALF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LED_COUNT:       cfg_ff.led_count       <= csr_pwdata[10:0];
            REG_BLANK_PER_LED:   cfg_ff.blank_per_led   <= csr_pwdata[9:0];
            REG_HALF_BIT_TICKS:  cfg_ff.half_bit_ticks  <= csr_pwdata[7:0];
            REG_LONG_BLANK_HALF: cfg_ff.long_blank_half <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         REG_LED_COUNT:       csr_prdata = 32'(cfg_ff.led_count);
         REG_BLANK_PER_LED:   csr_prdata = 32'(cfg_ff.blank_per_led);
         REG_HALF_BIT_TICKS:  csr_prdata = 32'(cfg_ff.half_bit_ticks);
         REG_LONG_BLANK_HALF: csr_prdata = 32'(cfg_ff.long_blank_half);
         default:             csr_prdata = '0;
      endcase
   end

   lcfs_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   lcfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   lcfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/lcfs_checker.sv
// Port-level checker for the LED chain frame serializer, bound to the top level.
`include "led_chain_frame_serializer_unit_defines.svh"

module lcfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled symbol holds until its transfer.
   `LCFS_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Reset leaves no symbol on the output.
   `LCFS_ASSERT_NEXT(a_rsp_reset, clock, reset, !rsp_tvalid)

   // A blank, low in both halves, always closes its command.
   `LCFS_ASSERT_IMPL(a_blank_last, clock, reset, rsp_tvalid && !rsp_tdata[0] && !rsp_tdata[19], rsp_tlast)

   // A symbol that starts high is a data one and falls in its second half.
   `LCFS_ASSERT_IMPL(a_one_falls, clock, reset, rsp_tvalid && rsp_tdata[0], !rsp_tdata[19])

endmodule

bind led_chain_frame_serializer_unit lcfs_checker u_lcfs_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the LED chain frame serializer unit.
module tb;
   import lcfs_pkg::*;

   localparam int MAX_LEDS = 1024;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 12;

   // Selector values that name no command.
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   // One expected line symbol, with the flags carried beside it.
   typedef struct packed {
      logic        first_level;
      logic [17:0] first_ticks;
      logic        second_level;
      logic [15:0] second_ticks;
      logic        seq_err;
      logic        last;
   } line_symbol_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: register copies and the slot expected next.
   cfg_type         model_cfg;
   logic [10:0]     next_slot;
   line_symbol_type expected_symbols[$];
   line_symbol_type want_sym;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int phase_items = 0;

   led_chain_frame_serializer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Run length guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready = 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every symbol transfer with the oldest expected symbol.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_symbols.size() == 0) begin
            $error("symbol transfer with no symbol expected");
            mismatch_count++;
         end else begin
            want_sym = expected_symbols.pop_front();
            check_field("first_level", want_sym.first_level, rsp_tdata[0]);
            check_field("first_ticks", want_sym.first_ticks, rsp_tdata[18:1]);
            check_field("second_level", want_sym.second_level, rsp_tdata[19]);
            check_field("second_ticks", want_sym.second_ticks, rsp_tdata[35:20]);
            check_field("sequence_error", want_sym.seq_err, rsp_tdata[36]);
            check_field("last_symbol", want_sym.last, rsp_tlast);
         end
      end
   end

   function automatic void queue_symbol(logic l0, logic [17:0] t0, logic l1, logic [15:0] t1,
                                        logic err);
      line_symbol_type s;
      s.first_level  = l0;
      s.first_ticks  = t0;
      s.second_level = l1;
      s.second_ticks = t1;
      s.seq_err      = err;
      s.last         = 1'b0;
      expected_symbols.push_back(s);
   endfunction

   // A one is high then low, a zero low then high.
   function automatic void queue_bit(logic value, logic err);
      logic [17:0] t0;
      logic [15:0] t1;
      t0 = {10'd0, model_cfg.half_bit_ticks};
      t1 = {8'd0, model_cfg.half_bit_ticks};
      queue_symbol(value, t0, ~value, t1, err);
   endfunction

   function automatic void queue_pattern(logic [SYM_BITS-1:0] pattern, int len);
      for (int i = len - 1; i >= 0; i--) queue_bit(pattern[i], 1'b0);
   endfunction

   function automatic void queue_long_blank();
      queue_symbol(1'b0, {2'b00, model_cfg.long_blank_half}, 1'b0, model_cfg.long_blank_half,
                   1'b0);
   endfunction

   // Expected symbols of one accepted command; also advances or clears the slot counter.
   function automatic void predict_symbols(logic [2:0] mode, logic [7:0] red, logic [7:0] green,
                                           logic [7:0] blue, logic [2:0] shift,
                                           logic [9:0] slot);
      logic [31:0]     total;
      logic [31:0]     first_wide;
      logic [10:0]     slot_limit;
      logic [11:0]     field;
      logic [7:0]      color [3];
      logic            err;
      logic            produced;
      line_symbol_type tail;
      produced = 1'b1;
      case (mode)
         MODE_RESET: begin
            queue_pattern(SYM_BITS'(RESET_PATTERN), HEADER_BITS);
            queue_long_blank();
         end
         MODE_SYNC: begin
            total = {21'd0, model_cfg.led_count} * {22'd0, model_cfg.blank_per_led};
            first_wide = (total == 0) ? 32'd0 : total - 32'd1;
            if (first_wide > {14'd0, FIRST_MAX}) first_wide = {14'd0, FIRST_MAX};
            queue_pattern(SYM_BITS'(SYNC_PATTERN), SYNC_BITS);
            queue_symbol(1'b0, first_wide[17:0], 1'b0, 16'd1, 1'b0);
         end
         MODE_START: begin
            queue_pattern(SYM_BITS'(START_PATTERN), HEADER_BITS);
            next_slot = '0;
         end
         MODE_PIXEL: begin
            slot_limit = (model_cfg.led_count < 11'(MAX_LEDS)) ? model_cfg.led_count
                                                               : 11'(MAX_LEDS);
            err = ({1'b0, slot} != next_slot) || ({1'b0, slot} >= slot_limit);
            color[0] = red;
            color[1] = green;
            color[2] = blue;
            for (int c = 0; c < 3; c++) begin
               // Bits shifted past the field are dropped.
               field = {4'd0, color[c]} << shift;
               queue_bit(1'b0, err);
               for (int b = CHANNEL_FIELD_BITS - 1; b >= 0; b--) queue_bit(field[b], err);
            end
            if (next_slot < SLOT_MAX) next_slot++;
         end
         MODE_FINAL: begin
            queue_pattern(SYM_BITS'(START_PATTERN), HEADER_BITS);
            queue_long_blank();
         end
         default: produced = 1'b0;
      endcase
      if (produced) begin
         tail = expected_symbols.pop_back();
         tail.last = 1'b1;
         expected_symbols.push_back(tail);
      end
   endfunction

   // Offer one command and wait for its transfer.
   task automatic send_command(logic [2:0] mode, logic [7:0] red, logic [7:0] green,
                               logic [7:0] blue, logic [2:0] shift, logic [9:0] slot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {3'd0, slot, shift, blue, green, red};
      req_tuser  = mode;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_symbols(mode, red, green, blue, shift, slot);
      if (mode <= MODE_FINAL) phase_items++;
   endtask

   task automatic send_plain(logic [2:0] mode);
      send_command(mode, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
                   10'($urandom));
   endtask

   task automatic send_pixel(logic [9:0] slot);
      send_command(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom_range(0, 7)), slot);
   endtask

   // Release the input and wait until every expected symbol has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_LED_COUNT:       model_cfg.led_count       = value[10:0];
         REG_BLANK_PER_LED:   model_cfg.blank_per_led   = value[9:0];
         REG_HALF_BIT_TICKS:  model_cfg.half_bit_ticks  = value[7:0];
         REG_LONG_BLANK_HALF: model_cfg.long_blank_half = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(int leds, int blank, int half, int long_half);
      wait_drained();
      write_register(REG_LED_COUNT, leds);
      write_register(REG_BLANK_PER_LED, blank);
      write_register(REG_HALF_BIT_TICKS, half);
      write_register(REG_LONG_BLANK_HALF, long_half);
   endtask

   // Every command and the pixel corner cases at reset register values.
   task automatic test_default_commands();
      send_plain(MODE_RESET);
      send_plain(MODE_SYNC);
      send_plain(MODE_START);
      send_command(MODE_PIXEL, 8'hFF, 8'h00, 8'hA5, 3'd0, 10'd0);
      send_command(MODE_PIXEL, 8'h00, 8'hFF, 8'h5A, 3'd4, 10'd1);
      // Large brightness pushes color bits out of the field.
      send_command(MODE_PIXEL, 8'hFF, 8'h81, 8'h7E, 3'd7, 10'd2);
      // Out of order slot.
      send_command(MODE_PIXEL, 8'h12, 8'h34, 8'h56, 3'd2, 10'd7);
      send_plain(MODE_SPARE_FIRST);
      send_plain(MODE_SPARE_LAST);
      send_plain(MODE_FINAL);
   endtask

   // Register extremes: saturated and empty sync blanks, zero durations.
   task automatic test_register_extremes();
      set_config(1024, 1023, 255, 65535);
      send_plain(MODE_SYNC);
      send_plain(MODE_START);
      send_command(MODE_PIXEL, 8'h01, 8'h80, 8'hFF, 3'd1, 10'd0);
      send_command(MODE_PIXEL, 8'hC3, 8'h3C, 8'h00, 3'd3, 10'd1023);
      send_plain(MODE_RESET);
      send_plain(MODE_FINAL);
      // Product of exactly one more than the saturation point.
      set_config(1024, 256, 17, 4096);
      send_plain(MODE_SYNC);
      set_config(1, 0, 0, 0);
      send_plain(MODE_SYNC);
      send_plain(MODE_START);
      send_command(MODE_PIXEL, 8'hAA, 8'h55, 8'hF0, 3'd5, 10'd0);
      // Beyond the chain length although in order.
      send_command(MODE_PIXEL, 8'h0F, 8'hFF, 8'h01, 3'd6, 10'd1);
      send_plain(MODE_RESET);
      send_plain(MODE_FINAL);
   endtask

   // Pixel counter runs past the chain length, then a start clears it.
   task automatic test_slot_overrun();
      set_config(10, 180, 3, 500);
      send_plain(MODE_START);
      for (int i = 0; i < 14; i++) send_pixel(10'(i));
      send_plain(MODE_START);
      send_pixel(10'd0);
   endtask

   // Receiver holds off for a long stretch while commands keep coming.
   task automatic test_output_hold_off();
      wait_drained();
      hold_off_left = 400;
      send_plain(MODE_START);
      for (int i = 0; i < 5; i++) send_pixel(10'(i));
      send_plain(MODE_SYNC);
   endtask

   // A frame with random content, sometimes with a misplaced or extra pixel.
   task automatic send_frame();
      int pixels;
      logic [9:0] slot;
      pixels = model_cfg.led_count;
      if ($urandom_range(99) < 30) send_plain(MODE_RESET);
      send_plain(MODE_SYNC);
      send_plain(MODE_START);
      for (int i = 0; i < pixels; i++) begin
         slot = 10'(i);
         if ($urandom_range(99) < 8) slot = 10'($urandom_range(0, 1023));
         send_pixel(slot);
      end
      if ($urandom_range(99) < 10) send_pixel(10'(pixels));
      send_plain(MODE_FINAL);
   endtask

   task automatic test_random_frames(int idle, int stall, int items);
      set_config($urandom_range(1, 6), $urandom_range(0, 1023), $urandom_range(1, 255),
                 $urandom_range(1, 65535));
      send_idle_pct = idle;
      stall_pct = stall;
      phase_items = 0;
      while (phase_items < items) begin
         if ($urandom_range(99) < 80) begin
            send_frame();
         end else begin
            // Noise: any selector, any slot.
            send_plain(3'($urandom_range(0, 7)));
         end
      end
      wait_drained();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      model_cfg.led_count       = LED_COUNT_RESET;
      model_cfg.blank_per_led   = BLANK_PER_LED_RESET;
      model_cfg.half_bit_ticks  = HALF_BIT_TICKS_RESET;
      model_cfg.long_blank_half = LONG_BLANK_HALF_RESET;
      next_slot = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_commands();
      test_register_extremes();
      test_slot_overrun();
      test_output_hold_off();
      test_random_frames(0, 0, 35);
      test_random_frames(46, 0, 35);
      test_random_frames(0, 46, 35);
      test_random_frames(15, 15, 35);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
